// ===== hdl/bmhq_pkg.sv =====
// Shared widths and codes for the binary min-heap priority queue.
package bmhq_pkg;

  localparam int unsigned ValueFieldW = 16;
  localparam int unsigned CountFieldW = 11;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_POP    = 1'b1
  } mode_e;

endpackage

// ===== hdl/bmhq_in_if.sv =====
// Request channel of the heap queue: an insert or a pop.
interface bmhq_in_if import bmhq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [ValueFieldW-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== hdl/bmhq_out_if.sv =====
// Result channel of the heap queue: one beat per request.
interface bmhq_out_if import bmhq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ValueFieldW-1:0] popped_value;
  logic [CountFieldW-1:0] entry_count;
  logic [ValueFieldW-1:0] front_value;
  status_e                status;

  modport source (output valid, output popped_value, output entry_count,
                  output front_value, output status, input ready);
  modport sink   (input valid, input popped_value, input entry_count,
                  input front_value, input status, output ready);
endinterface

// ===== hdl/binary_min_heap_queue_top.sv =====
// Binary min-heap priority queue built around one heap memory.
//
// Each request beat either inserts a value or pops the smallest stored value,
// and each produces exactly one result beat carrying the popped value, the
// new entry count, the new minimum and a status. Requests are handled one at
// a time. Each heap level the entry moves costs a memory read state and a
// compare-and-write state, because the heap lives in a single synchronous
// memory with registered reads. A rejected request, or a pop that empties
// the heap, goes straight to the result state. The block goes back to idle
// and takes the next request once the result is loaded into the output
// register, and that load waits while the consumer holds off the previous
// result. The result is held in an output register, so a new request is
// taken while the previous result still waits for the consumer. An insert
// into a full heap and a pop from an empty heap are rejected with a status
// code and leave the heap untouched. The heap memory is not cleared after
// reset; only entries below the fill count are ever used.
module binary_min_heap_queue_top import bmhq_pkg::*; #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmhq_in_if.sink    in_i,
  bmhq_out_if.source out_o
);

  // Slots are numbered 1..CAPACITY as in a textbook heap; memory address is
  // slot - 1. A child slot index can reach 2 * CAPACITY, hence the extra bit.
  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned SW    = CW + 1;
  localparam int unsigned WIDEV = VALUE_WIDTH + ValueFieldW;
  localparam int unsigned WIDEC = CW + CountFieldW;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_UP_RD   = 7'b0000010,
    ST_UP_CMP  = 7'b0000100,
    ST_DN_LAST = 7'b0001000,
    ST_DN_RD   = 7'b0010000,
    ST_DN_CMP  = 7'b0100000,
    ST_FIN     = 7'b1000000
  } state_e;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [SW-1:0]          slot_t;

  function automatic logic [AW-1:0] slot_addr(slot_t slot);
    slot_t off;
    off = slot - slot_t'(1);
    return off[AW-1:0];
  endfunction

  // Heap storage and its two registered read ports.
  value_t mem_q [CAPACITY];
  value_t rd_a_q, rd_b_q;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  slot_t         slot_q, slot_d;
  value_t        cur_q, cur_d;
  value_t        root_q, root_d;
  value_t        pop_q, pop_d;
  status_e       stat_q, stat_d;

  logic                   out_valid_q;
  logic [ValueFieldW-1:0] out_pop_q;
  logic [CountFieldW-1:0] out_cnt_q;
  logic [ValueFieldW-1:0] out_front_q;
  status_e                out_stat_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  value_t        mem_wdata;
  logic [AW-1:0] rd_a_addr, rd_b_addr;

  logic          in_fire;
  logic          out_load;
  value_t        in_val;
  logic [WIDEV-1:0] in_wide;
  slot_t         cnt_slot;
  slot_t         child;
  logic          use_right;
  value_t        child_val;
  slot_t         child_slot;

  // Input value keeps only its low VALUE_WIDTH bits.
  assign in_wide  = {{(WIDEV - ValueFieldW){1'b0}}, in_i.value};
  assign in_val   = in_wide[VALUE_WIDTH-1:0];
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);

  assign cnt_slot   = {1'b0, cnt_q};
  assign child      = {slot_q[SW-2:0], 1'b0};
  // Right child wins only when it exists and is strictly smaller.
  assign use_right  = (child < cnt_slot) && (rd_b_q < rd_a_q);
  assign child_val  = use_right ? rd_b_q : rd_a_q;
  assign child_slot = use_right ? (child + slot_t'(1)) : child;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    slot_d    = slot_q;
    cur_d     = cur_q;
    root_d    = root_q;
    pop_d     = pop_q;
    stat_d    = stat_q;
    mem_we    = 1'b0;
    mem_waddr = slot_addr(slot_q);
    mem_wdata = cur_q;
    rd_a_addr = slot_addr(slot_q >> 1);
    rd_b_addr = rd_a_addr;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          pop_d  = '0;
          stat_d = STATUS_DONE;
          if (in_i.mode == MODE_INSERT) begin
            if (cnt_q == CW'(CAPACITY)) begin
              stat_d  = STATUS_FULL;
              state_d = ST_FIN;
            end else begin
              cnt_d   = cnt_q + CW'(1);
              slot_d  = cnt_slot + slot_t'(1);
              cur_d   = in_val;
              state_d = ST_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              stat_d  = STATUS_EMPTY;
              state_d = ST_FIN;
            end else begin
              pop_d = root_q;
              cnt_d = cnt_q - CW'(1);
              if (cnt_q == CW'(1)) begin
                state_d = ST_FIN;
              end else begin
                // Fetch the last entry; it refills the root.
                rd_a_addr = slot_addr(cnt_slot);
                slot_d    = slot_t'(1);
                state_d   = ST_DN_LAST;
              end
            end
          end
        end
      end

      ST_UP_RD: begin
        if (slot_q == slot_t'(1)) begin
          mem_we  = 1'b1;
          root_d  = cur_q;
          state_d = ST_FIN;
        end else begin
          state_d = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        mem_we = 1'b1;
        if (rd_a_q > cur_q) begin
          // Parent moves down into the hole; the hole climbs one level.
          mem_wdata = rd_a_q;
          slot_d    = slot_q >> 1;
          state_d   = ST_UP_RD;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_DN_LAST: begin
        cur_d   = rd_a_q;
        state_d = ST_DN_RD;
      end

      ST_DN_RD: begin
        if (child > cnt_slot) begin
          mem_we = 1'b1;
          if (slot_q == slot_t'(1)) begin
            root_d = cur_q;
          end
          state_d = ST_FIN;
        end else begin
          rd_a_addr = slot_addr(child);
          rd_b_addr = (child < cnt_slot) ? slot_addr(child + slot_t'(1)) : slot_addr(child);
          state_d   = ST_DN_CMP;
        end
      end

      ST_DN_CMP: begin
        mem_we = 1'b1;
        if (child_val < cur_q) begin
          // Smaller child moves up into the hole; the hole sinks one level.
          mem_wdata = child_val;
          if (slot_q == slot_t'(1)) begin
            root_d = child_val;
          end
          slot_d  = child_slot;
          state_d = ST_DN_RD;
        end else begin
          if (slot_q == slot_t'(1)) begin
            root_d = cur_q;
          end
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem_q[rd_a_addr];
    rd_b_q <= mem_q[rd_b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [WIDEV-1:0] pop_wide, front_wide;
  logic [WIDEC-1:0] cnt_wide;

  assign pop_wide   = {{ValueFieldW{1'b0}}, pop_q};
  assign front_wide = (cnt_q != '0) ? {{ValueFieldW{1'b0}}, root_q} : '0;
  assign cnt_wide   = {{CountFieldW{1'b0}}, cnt_q};

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    cur_q  <= cur_d;
    root_q <= root_d;
    pop_q  <= pop_d;
    stat_q <= stat_d;
    if (out_load) begin
      out_pop_q   <= pop_wide[ValueFieldW-1:0];
      out_cnt_q   <= cnt_wide[CountFieldW-1:0];
      out_front_q <= front_wide[ValueFieldW-1:0];
      out_stat_q  <= stat_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = out_pop_q;
  assign out_o.entry_count  = out_cnt_q;
  assign out_o.front_value  = out_front_q;
  assign out_o.status       = out_stat_q;

endmodule

// ===== sim/binary_min_heap_queue_top_tb.sv =====
// Self-checking testbench for the binary min-heap priority queue.
module binary_min_heap_queue_top_tb import bmhq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default sizes. The value mask keeps the low
  // VALUE_WIDTH bits of an inserted value, as the queue itself does.
  localparam int unsigned HeapDepth = 1024;
  localparam int unsigned ValueBits = 16;
  localparam logic [ValueFieldW-1:0] ValueMask =
      ValueFieldW'((33'd1 << ValueBits) - 33'd1);

  // After the last beat the queue gets this many cycles to show any stray
  // result. This is more than the worst insert or pop time.
  localparam int unsigned TailCycles = 60;

  // One planned request beat. A request marked hold is not sent before every
  // earlier request has its result back. A request marked quiet turns off all
  // idling on both sides.
  typedef struct {
    mode_e                  mode;
    logic [ValueFieldW-1:0] value;
    bit                     hold;
    bit                     quiet;
  } heap_request_t;

  // The result beat expected for one request.
  typedef struct {
    logic [ValueFieldW-1:0] popped;
    logic [CountFieldW-1:0] count;
    logic [ValueFieldW-1:0] front;
    status_e                status;
  } heap_result_t;

  logic clk_i;
  logic rst_ni;

  bmhq_in_if  req_if ();
  bmhq_out_if rsp_if ();

  binary_min_heap_queue_top #(
    .CAPACITY   (HeapDepth),
    .VALUE_WIDTH(ValueBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  // The stimulus queue is filled before reset is released. Results are
  // predicted when a request beat is accepted, and they are stored in order.
  heap_request_t request_queue[$];
  heap_result_t  expected_results[$];

  // Both beat counters are updated with nonblocking assignments. At a clock
  // edge the driver and the monitor therefore see the same values, whatever
  // order the two always blocks run in.
  int unsigned requests_taken = 0;
  int unsigned results_taken  = 0;
  int unsigned error_count    = 0;

  int unsigned send_gap    = 0;
  int unsigned ready_stall = 0;
  bit          quiet_tail  = 1'b0;

  // Fill count of the planned sequence. The generator uses it to steer the
  // heap toward empty or toward full.
  int unsigned plan_fill = 0;

  // The predictor keeps its own copy of the heap. Slot 1 is the root, and
  // the children of slot k are 2k and 2k+1.
  logic [ValueFieldW-1:0] heap_model [1:HeapDepth];
  int unsigned            heap_fill = 0;

  // Applies one request to the predicted heap and returns the result beat
  // that the queue must produce. An insert sifts up and swaps only while the
  // parent is strictly greater. A pop moves the last entry to the root and
  // sifts down toward the smaller child, the left one on a tie. A rejected
  // request leaves the heap as it was.
  function automatic heap_result_t apply_request(mode_e mode,
                                                 logic [ValueFieldW-1:0] value);
    heap_result_t           res;
    int unsigned            slot;
    int unsigned            child;
    logic [ValueFieldW-1:0] spare;
    res.popped = '0;
    res.status = STATUS_DONE;
    if (mode == MODE_INSERT) begin
      if (heap_fill >= HeapDepth) begin
        res.status = STATUS_FULL;
      end else begin
        heap_fill++;
        slot = heap_fill;
        heap_model[slot] = value & ValueMask;
        while (slot > 1 && heap_model[slot / 2] > heap_model[slot]) begin
          spare                = heap_model[slot / 2];
          heap_model[slot / 2] = heap_model[slot];
          heap_model[slot]     = spare;
          slot                 = slot / 2;
        end
      end
    end else if (heap_fill == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.popped    = heap_model[1];
      heap_model[1] = heap_model[heap_fill];
      heap_fill--;
      slot = 1;
      while (2 * slot <= heap_fill) begin
        child = 2 * slot;
        if (child < heap_fill && heap_model[child + 1] < heap_model[child]) begin
          child++;
        end
        if (heap_model[child] < heap_model[slot]) begin
          spare             = heap_model[child];
          heap_model[child] = heap_model[slot];
          heap_model[slot]  = spare;
          slot              = child;
        end else begin
          break;
        end
      end
    end
    res.count = heap_fill[CountFieldW-1:0];
    res.front = (heap_fill > 0) ? heap_model[1] : '0;
    return res;
  endfunction

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void check_field(string name, int unsigned beat,
                                      logic [ValueFieldW-1:0] want,
                                      logic [ValueFieldW-1:0] got);
    if (got !== want) begin
      report_error($sformatf("result beat %0d: %s expected %h, got %h",
                             beat, name, want, got));
    end
  endfunction

  // Value mix: about one in six comes from a narrow range so that equal keys
  // meet in the heap, one in six is an extreme of the field, and the rest
  // spread over the whole field.
  function automatic logic [ValueFieldW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        return ValueFieldW'($urandom_range(0, 15));
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 16'h7FFF;
          default: return 16'h8000;
        endcase
      end
      default: begin
        return ValueFieldW'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  // Appends one request to the plan and tracks the fill count it leads to.
  function automatic void plan_request(mode_e mode, logic [ValueFieldW-1:0] value,
                                       bit hold = 1'b0);
    heap_request_t req;
    req.mode  = mode;
    req.value = value;
    req.hold  = hold;
    req.quiet = 1'b0;
    request_queue.push_back(req);
    if (mode == MODE_INSERT && plan_fill < HeapDepth) begin
      plan_fill++;
    end else if (mode == MODE_POP && plan_fill > 0) begin
      plan_fill--;
    end
  endfunction

  function automatic void build_stimulus();
    int unsigned idx;
    // Directed opening. It starts with a pop from the empty heap. Then come
    // inserts of the extreme values in an order that makes them sift up, a
    // repeated minimum, and a drain that ends in a second rejected pop.
    // Pops carry junk in the value field, which the queue must ignore.
    plan_request(MODE_POP,    16'hFFFF);
    plan_request(MODE_INSERT, 16'hFFFF);
    plan_request(MODE_INSERT, 16'h0000);
    plan_request(MODE_INSERT, 16'h8000);
    plan_request(MODE_INSERT, 16'h0000);
    plan_request(MODE_INSERT, 16'h0001);
    plan_request(MODE_INSERT, 16'h7FFF);
    repeat (6) plan_request(MODE_POP, pick_value());
    plan_request(MODE_POP,    16'h0000);
    plan_request(MODE_INSERT, 16'hAAAA);
    plan_request(MODE_INSERT, 16'h5555);
    plan_request(MODE_INSERT, 16'h5555);
    plan_request(MODE_POP,    16'h5555);
    plan_request(MODE_INSERT, 16'h5554);
    plan_request(MODE_POP,    16'hAAAA);
    plan_request(MODE_POP,    16'hFFFF);
    plan_request(MODE_POP,    16'h0001);
    plan_request(MODE_POP,    16'h8000);

    // Random work near the empty heap. Inserts and pops are even, so pops
    // from the empty heap keep showing up.
    repeat (60) begin
      plan_request($urandom_range(0, 1) ? MODE_POP : MODE_INSERT, pick_value());
    end

    // Fill the heap up to its capacity, mostly with inserts. The first
    // request of this stretch waits until the queue has gone quiet.
    plan_request(MODE_INSERT, pick_value(), 1'b1);
    while (plan_fill < HeapDepth) begin
      plan_request($urandom_range(0, 19) == 0 ? MODE_POP : MODE_INSERT, pick_value());
    end

    // Stay close to full, so that some inserts get rejected and some pops
    // sift down through the deepest level.
    repeat (60) begin
      plan_request($urandom_range(0, 9) < 7 ? MODE_INSERT : MODE_POP, pick_value());
    end

    // Mostly pops from a nearly full heap. The queue drains again first.
    plan_request(MODE_POP, pick_value(), 1'b1);
    repeat (100) begin
      plan_request($urandom_range(0, 9) == 0 ? MODE_INSERT : MODE_POP, pick_value());
    end

    // The last requests run with no idling on either side.
    for (idx = request_queue.size() - 150; idx < request_queue.size(); idx++) begin
      request_queue[idx].quiet = 1'b1;
    end
  endfunction

  // Request driver. A beat is taken at the edge where valid and ready are
  // both high. The next beat is offered only when the slot is free: valid
  // was low, or the current beat is taken at this edge. A random gap follows
  // about one beat in four, except in the quiet tail.
  always @(posedge clk_i) begin
    heap_request_t next_req;
    bit            taken_now;
    if (rst_ni) begin
      taken_now = req_if.valid && req_if.ready;
      if (taken_now) begin
        expected_results.push_back(apply_request(mode_e'(req_if.mode), req_if.value));
        requests_taken <= requests_taken + 1;
      end
      if (!req_if.valid || taken_now) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (request_queue.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (request_queue[0].hold &&
                     (taken_now || requests_taken != results_taken)) begin
          // A hold request waits until every earlier result has come back.
          req_if.valid <= 1'b0;
        end else begin
          next_req = request_queue.pop_front();
          req_if.valid <= 1'b1;
          req_if.mode  <= next_req.mode;
          req_if.value <= next_req.value;
          quiet_tail   <= next_req.quiet;
          if (!next_req.quiet && $urandom_range(0, 3) == 0) begin
            send_gap = $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Result monitor. Each result beat is matched with the oldest prediction.
  // A result beat that arrives when every request already has its result is
  // an error. Ready drops in random bursts, except in the quiet tail.
  always @(posedge clk_i) begin
    heap_result_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_taken <= results_taken + 1;
        if (results_taken == requests_taken) begin
          report_error($sformatf("result beat %0d has no request: popped %h count %0d",
                                 results_taken, rsp_if.popped_value,
                                 rsp_if.entry_count));
        end else begin
          want = expected_results.pop_front();
          check_field("popped_value", results_taken, want.popped, rsp_if.popped_value);
          check_field("entry_count", results_taken, ValueFieldW'(want.count),
                      ValueFieldW'(rsp_if.entry_count));
          check_field("front_value", results_taken, want.front, rsp_if.front_value);
          check_field("status", results_taken, ValueFieldW'(want.status),
                      ValueFieldW'(rsp_if.status));
        end
      end
      if (ready_stall > 0) begin
        ready_stall--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        ready_stall = $urandom_range(0, 7);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit. A correct run needs well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    // All inputs of the queue have known values from time zero.
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.mode  = MODE_INSERT;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    build_stimulus();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until the plan has been sent and every request has its result.
    // Then allow some further cycles in which a stray beat would show up.
    do begin
      @(posedge clk_i);
    end while (request_queue.size() != 0 || req_if.valid ||
               requests_taken != results_taken);
    repeat (TailCycles) @(posedge clk_i);
    if (requests_taken > results_taken) begin
      report_error($sformatf("%0d results never arrived",
                             requests_taken - results_taken));
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
